// ===== hw/rtl/tod_pkg.sv =====
// Shared types and constants for the time-of-day keeper.
// Used by tod_line, tod_core and the top level; depends on nothing.
package tod_pkg;

	// Tick rate and day cycle.
	localparam int TICKS_PER_SECOND = 1000;
	localparam int DAYS_PER_CYCLE   = 31;
	localparam int PHASE_W          = $clog2(TICKS_PER_SECOND + 1);

	// Time limits.
	localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN   = 17'd60;
	localparam logic [16:0] LAST_SEC_OF_DAY = 17'd86399;
	localparam logic [6:0]  MAX_HOUR       = 7'd23;
	localparam logic [6:0]  MAX_MIN_SEC    = 7'd59;
	localparam logic [6:0]  MAX_DAY        = 7'd31;

	// ISO line length, YYYY-MM-DD,HH:MM:SS.
	localparam logic [4:0] LINE_LEN = 5'd19;

	// Register map, selected by paddr[2].
	localparam logic REG_NIGHT_START = 1'b0;
	localparam logic REG_NIGHT_END   = 1'b1;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_SEED = 2'd1,
		ACT_CHAR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	// Seed request from the line parser, raised on the terminating zero byte.
	typedef struct packed {
		logic       req;
		logic       well_formed;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [6:0] day;
	} seed_req_t;

	// One result word.
	typedef struct packed {
		status_t     status;
		logic        valid;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [16:0] sod;
		logic [4:0]  day;
		logic        night;
	} result_t;

endpackage

// ===== hw/rtl/tod_line.sv =====
// ISO line parser: checks YYYY-MM-DD,HH:MM:SS and collects day and time digits.
// Depends on tod_pkg.
module tod_line (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          char_in,
	output tod_pkg::seed_req_t  seed_req
);

	logic [4:0] pos_q;
	logic       err_q;
	logic [6:0] val_q [4];

	logic [7:0] expect_chr;
	logic       is_digit;
	logic [2:0] slot;
	logic [3:0] digit;

	// Expected byte at each position; '0' stands for any digit.
	always_comb begin
		case (pos_q)
			5'd4, 5'd7:   expect_chr = 8'h2D;
			5'd10:        expect_chr = 8'h2C;
			5'd13, 5'd16: expect_chr = 8'h3A;
			default:      expect_chr = 8'h30;
		endcase
	end

	// Which collected value the digit at this position belongs to; 4 means none.
	always_comb begin
		case (pos_q)
			5'd8, 5'd9:   slot = 3'd0;
			5'd11, 5'd12: slot = 3'd1;
			5'd14, 5'd15: slot = 3'd2;
			5'd17, 5'd18: slot = 3'd3;
			default:      slot = 3'd4;
		endcase
	end

	assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
	assign digit    = 4'(char_in - 8'h30);

	// The zero byte ends the line and hands the collected fields over.
	assign seed_req.req         = (char_in == 8'h00);
	assign seed_req.well_formed = (pos_q == tod_pkg::LINE_LEN) && !err_q;
	assign seed_req.day         = val_q[0];
	assign seed_req.hour        = val_q[1];
	assign seed_req.minute      = val_q[2];
	assign seed_req.second      = val_q[3];

	// Line state update. A slot starts from zero, so it holds at most one digit
	// before the second one arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
			for (int i = 0; i < 4; i++) val_q[i] <= '0;
		end else if (fire) begin
			if (char_in == 8'h00) begin
				pos_q <= '0;
				err_q <= 1'b0;
				for (int i = 0; i < 4; i++) val_q[i] <= '0;
			end else if (pos_q >= tod_pkg::LINE_LEN) begin
				err_q <= 1'b1;
			end else begin
				if (expect_chr == 8'h30) begin
					if (!is_digit) begin
						err_q <= 1'b1;
					end else if (slot != 3'd4) begin
						val_q[slot[1:0]] <= 7'(val_q[slot[1:0]][3:0] * 7'd10)
							+ 7'(digit);
					end
				end else if (char_in != expect_chr) begin
					err_q <= 1'b1;
				end
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	// The position saturates at the line length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= tod_pkg::LINE_LEN)
		else $error("line position past line length");

	// Collected values are at most two decimal digits.
	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		val_q[0] <= 7'd99 && val_q[1] <= 7'd99 && val_q[2] <= 7'd99 && val_q[3] <= 7'd99)
		else $error("collected value above two digits");

	// A line end starts a clean line.
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && char_in == 8'h00 |=> pos_q == 5'd0 && !err_q)
		else $error("line state not cleared at line end");

endmodule

// ===== hw/rtl/tod_core.sv =====
// Time keeping core: seed check and load, tick counting, result formatting.
// Depends on tod_pkg.
module tod_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [1:0]          action,
	input  logic [4:0]          hour_in,
	input  logic [5:0]          minute_in,
	input  logic [5:0]          second_in,
	input  logic [5:0]          day_in,
	input  tod_pkg::seed_req_t  line_req,
	input  logic [4:0]          night_start,
	input  logic [4:0]          night_end,
	output tod_pkg::result_t    res
);

	logic                        valid_q, valid_d;
	logic [tod_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [16:0]                 sod_q, sod_d;
	logic [4:0]                  hour_q, hour_d;
	logic [5:0]                  min_q, min_d;
	logic [5:0]                  sec_q, sec_d;
	logic [4:0]                  day_q, day_d;

	tod_pkg::seed_req_t seed;
	tod_pkg::status_t   status;
	logic               seed_in_range;
	logic [16:0]        sod_load;
	logic               night;

	// Pick the seed source for this word.
	always_comb begin
		seed = '0;
		case (action)
			tod_pkg::ACT_SEED: begin
				seed.req         = 1'b1;
				seed.well_formed = 1'b1;
				seed.hour        = 7'(hour_in);
				seed.minute      = 7'(minute_in);
				seed.second      = 7'(second_in);
				seed.day         = 7'(day_in);
			end
			tod_pkg::ACT_CHAR: seed = line_req;
			default: seed = '0;
		endcase
	end

	assign seed_in_range = (seed.hour <= tod_pkg::MAX_HOUR)
		&& (seed.minute <= tod_pkg::MAX_MIN_SEC)
		&& (seed.second <= tod_pkg::MAX_MIN_SEC)
		&& (seed.day <= tod_pkg::MAX_DAY);

	assign sod_load = 17'(seed.hour[4:0]) * tod_pkg::SECS_PER_HOUR
		+ 17'(seed.minute[5:0]) * tod_pkg::SECS_PER_MIN
		+ 17'(seed.second[5:0]);

	// Next state: an accepted seed loads the counters, the day only when nonzero;
	// a tick after seeding carries through millisecond, second, minute, hour and day.
	always_comb begin
		valid_d = valid_q;
		phase_d = phase_q;
		sod_d   = sod_q;
		hour_d  = hour_q;
		min_d   = min_q;
		sec_d   = sec_q;
		day_d   = day_q;
		status  = tod_pkg::ST_NONE;
		if (seed.req) begin
			if (seed.well_formed && seed_in_range) begin
				status  = tod_pkg::ST_ACCEPT;
				valid_d = 1'b1;
				phase_d = '0;
				sod_d   = sod_load;
				hour_d  = seed.hour[4:0];
				min_d   = seed.minute[5:0];
				sec_d   = seed.second[5:0];
				if (seed.day != 7'd0) day_d = seed.day[4:0];
			end else begin
				status = tod_pkg::ST_REJECT;
			end
		end else if (action == tod_pkg::ACT_TICK && valid_q) begin
			if (phase_q != tod_pkg::PHASE_W'(tod_pkg::TICKS_PER_SECOND - 1)) begin
				phase_d = phase_q + tod_pkg::PHASE_W'(1);
			end else begin
				phase_d = '0;
				if (sod_q == tod_pkg::LAST_SEC_OF_DAY) begin
					sod_d  = '0;
					hour_d = '0;
					min_d  = '0;
					sec_d  = '0;
					if (day_q >= 5'(tod_pkg::DAYS_PER_CYCLE)) day_d = 5'd1;
					else day_d = day_q + 5'd1;
				end else begin
					sod_d = sod_q + 17'd1;
					if (sec_q != 6'd59) begin
						sec_d = sec_q + 6'd1;
					end else begin
						sec_d = '0;
						if (min_q != 6'd59) begin
							min_d = min_q + 6'd1;
						end else begin
							min_d  = '0;
							hour_d = hour_q + 5'd1;
						end
					end
				end
			end
		end
	end

	// Night window, including a window that wraps past midnight; equal bounds give no night.
	always_comb begin
		if (night_start < night_end)
			night = (hour_d >= night_start) && (hour_d < night_end);
		else if (night_start > night_end)
			night = (hour_d >= night_start) || (hour_d < night_end);
		else
			night = 1'b0;
	end

	// Result word, taken after the update; time reads zero until seeded.
	always_comb begin
		res        = '0;
		res.status = status;
		res.valid  = valid_d;
		if (valid_d) begin
			res.hour   = hour_d;
			res.minute = min_d;
			res.second = sec_d;
			res.sod    = sod_d;
			res.day    = day_d;
			res.night  = night;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= '0;
			sod_q   <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			day_q   <= 5'd1;
		end else if (fire) begin
			valid_q <= valid_d;
			phase_q <= phase_d;
			sod_q   <= sod_d;
			hour_q  <= hour_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			day_q   <= day_d;
		end
	end

	// The split counters and the second-of-day counter agree.
	a_sod_match: assert property (@(posedge clk) disable iff (!arst_n)
		sod_q == 17'(hour_q) * tod_pkg::SECS_PER_HOUR + 17'(min_q) * tod_pkg::SECS_PER_MIN
			+ 17'(sec_q))
		else $error("second of day out of step with hour, minute, second");

	// Counters stay within a day.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_q <= 5'd23 && min_q <= 6'd59 && sec_q <= 6'd59 && day_q != 5'd0)
		else $error("time counter out of range");

	// Time does not run before the first accepted seed.
	a_idle_unseeded: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> phase_q == '0 && sod_q == 17'd0)
		else $error("time ran before seeding");

endmodule

// ===== hw/rtl/time_of_day_keeper_with_iso_seed.sv =====
// Top level of the time-of-day keeper: APB registers, input and result registers.
// Depends on tod_pkg, tod_line and tod_core.
//
// Usage: each input word on the in channel (in_valid/in_ready) is one
// millisecond tick, one seed given as fields, or one character of an ISO line
// YYYY-MM-DD,HH:MM:SS ended by a zero byte. Each word yields exactly one result
// word on the out channel (out_valid/out_ready) with the seed answer, the time,
// the day and the night flag as they stand after that word.
// A word accepted into the input register goes through the state update and
// result formatting into the result register, raising out_valid. Throughput is
// one word per cycle while the receiver takes results; the state update between
// those two registers is combinational.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_ready falls only when both are full.
// Reset clears the time (not valid), sets the day to 1, clears the line parser
// and loads the night window as 22 to 5. The night registers sit at byte
// addresses 0 and 4; a write whose pwdata[4:0] is above 23 is ignored. Write them only
// while no word is in flight.
module time_of_day_keeper_with_iso_seed (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	input  logic [5:0]  day_in,
	input  logic [7:0]  char_in,
	// Result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  seed_status,
	output logic        time_valid,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out,
	output logic [16:0] second_of_day_out,
	output logic [4:0]  day_out,
	output logic        night_now,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [4:0] night_start_r_q;
	logic [4:0] night_end_q;

	logic       item_valid_s1;
	logic [1:0] action_s1;
	logic [4:0] hour_s1;
	logic [5:0] minute_s1;
	logic [5:0] second_s1;
	logic [5:0] day_s1;
	logic [7:0] char_s1;

	logic             out_valid_q;
	tod_pkg::result_t res_q;

	logic               advance;
	logic               cfg_write;
	tod_pkg::seed_req_t line_req;
	tod_pkg::result_t   res;

	// Configuration registers.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_start_r_q <= 5'd22;
			night_end_q     <= 5'd5;
		end else if (cfg_write && pwdata[4:0] <= 5'd23) begin
			unique case (paddr[2])
				tod_pkg::REG_NIGHT_START: night_start_r_q <= pwdata[4:0];
				tod_pkg::REG_NIGHT_END:   night_end_q     <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Readback; the zero-extended hour of the selected register.
	always_comb begin
		unique case (paddr[2])
			tod_pkg::REG_NIGHT_START: prdata = 32'(night_start_r_q);
			tod_pkg::REG_NIGHT_END:   prdata = 32'(night_end_q);
			default:                  prdata = '0;
		endcase
	end

	// Handshake: the input register moves on when the result register is free.
	assign advance  = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !item_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			hour_s1   <= hour_in;
			minute_s1 <= minute_in;
			second_s1 <= second_in;
			day_s1    <= day_in;
			char_s1   <= char_in;
		end
	end

	// Line parser.
	tod_line u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance && action_s1 == tod_pkg::ACT_CHAR),
		.char_in  (char_s1),
		.seed_req (line_req)
	);

	// Time keeping core.
	tod_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.action      (action_s1),
		.hour_in     (hour_s1),
		.minute_in   (minute_s1),
		.second_in   (second_s1),
		.day_in      (day_s1),
		.line_req    (line_req),
		.night_start (night_start_r_q),
		.night_end   (night_end_q),
		.res         (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign out_valid         = out_valid_q;
	assign seed_status       = res_q.status;
	assign time_valid        = res_q.valid;
	assign hour_out          = res_q.hour;
	assign minute_out        = res_q.minute;
	assign second_out        = res_q.second;
	assign second_of_day_out = res_q.sod;
	assign day_out           = res_q.day;
	assign night_now         = res_q.night;

endmodule

// ===== tb/time_of_day_keeper_with_iso_seed_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the time-of-day keeper: seeds, ISO lines and ticks
// are predicted in the bench and compared word by word. Depends on tod_pkg and the top.
module time_of_day_keeper_with_iso_seed_tb;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam logic [7:0] CH_ZERO      = "0";
	localparam logic [7:0] CH_NINE      = "9";
	localparam logic [7:0] CH_DASH      = "-";
	localparam logic [7:0] CH_COMMA     = ",";
	localparam logic [7:0] CH_COLON     = ":";
	localparam logic [7:0] CH_END       = 8'h00;
	localparam logic [7:0] NO_SEP       = 8'h00;
	localparam int         PHASE_WORDS  = 80;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 6;
	localparam int         LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic [1:0] act;
		logic [4:0] hr;
		logic [5:0] mn;
		logic [5:0] sc;
		logic [5:0] dy;
		logic [7:0] ch;
	} tod_word_t;

	typedef enum int {LINE_GOOD, LINE_CORRUPT, LINE_SHORT, LINE_LONG} line_kind_t;

	// Ports of the block; the bench's own drives are all known from time zero.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = tod_pkg::ACT_TICK;
	logic [4:0]  hour_in = '0;
	logic [5:0]  minute_in = '0;
	logic [5:0]  second_in = '0;
	logic [5:0]  day_in = '0;
	logic [7:0]  char_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  seed_status;
	logic        time_valid;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic [16:0] second_of_day_out;
	logic [4:0]  day_out;
	logic        night_now;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Bench state.
	tod_word_t         tod_word_q[$];
	tod_pkg::result_t  tod_result_q[$];
	tod_word_t         word_cur;
	tod_pkg::result_t  want_res;
	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_results = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	int          tx_gap_pct = 0;
	int          rx_stall_pct = 0;
	logic        hold_go = 1'b0;
	logic        rx_hold = 1'b0;

	// Predicted state of the keeper and its night window.
	logic        tod_valid;
	int unsigned ms_cnt;
	int unsigned tod_sec;
	int unsigned tod_day;
	int unsigned ln_pos;
	logic        ln_bad;
	int unsigned ln_val[4];
	int unsigned night_lo;
	int unsigned night_hi;

	time_of_day_keeper_with_iso_seed u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .hour_in(hour_in), .minute_in(minute_in),
		.second_in(second_in), .day_in(day_in), .char_in(char_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.seed_status(seed_status), .time_valid(time_valid),
		.hour_out(hour_out), .minute_out(minute_out), .second_out(second_out),
		.second_of_day_out(second_of_day_out), .day_out(day_out),
		.night_now(night_now),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got %0h want %0h", n_results, name, got, want));
	endtask

	// Separator expected at a line position, or NO_SEP where a digit belongs.
	function automatic logic [7:0] line_sep(input int unsigned pos);
		case (pos)
			4, 7:   return CH_DASH;
			10:     return CH_COMMA;
			13, 16: return CH_COLON;
			default: return NO_SEP;
		endcase
	endfunction

	// A range check, then the load; a rejected seed leaves everything alone.
	function automatic tod_pkg::status_t seed_time(input int unsigned hr, mn, sc, dy);
		if (hr > tod_pkg::MAX_HOUR || mn > tod_pkg::MAX_MIN_SEC || sc > tod_pkg::MAX_MIN_SEC
			|| dy > tod_pkg::MAX_DAY)
			return tod_pkg::ST_REJECT;
		tod_sec = hr * tod_pkg::SECS_PER_HOUR + mn * tod_pkg::SECS_PER_MIN + sc;
		ms_cnt = 0;
		if (dy >= 1)
			tod_day = dy;
		else if (tod_day < 1 || tod_day > tod_pkg::MAX_DAY)
			tod_day = 1;
		tod_valid = 1'b1;
		return tod_pkg::ST_ACCEPT;
	endfunction

	function automatic void tick_ms();
		if (!tod_valid)
			return;
		ms_cnt++;
		if (ms_cnt < tod_pkg::TICKS_PER_SECOND)
			return;
		ms_cnt = 0;
		tod_sec++;
		if (tod_sec <= tod_pkg::LAST_SEC_OF_DAY)
			return;
		tod_sec = 0;
		tod_day = (tod_day >= tod_pkg::DAYS_PER_CYCLE) ? 1 : tod_day + 1;
	endfunction

	// One character of the ISO line; the zero byte closes the line and answers.
	function automatic tod_pkg::status_t take_line_char(input logic [7:0] c);
		tod_pkg::status_t st;
		logic [7:0]       sep;
		int               slot;
		st = tod_pkg::ST_NONE;
		if (c == CH_END) begin
			if (ln_pos == tod_pkg::LINE_LEN && !ln_bad)
				st = seed_time(ln_val[1], ln_val[2], ln_val[3], ln_val[0]);
			else
				st = tod_pkg::ST_REJECT;
			ln_pos = 0;
			ln_bad = 1'b0;
			ln_val = '{default: 0};
			return st;
		end
		if (ln_pos >= tod_pkg::LINE_LEN) begin
			ln_bad = 1'b1;
			return st;
		end
		sep = line_sep(ln_pos);
		if (sep == NO_SEP) begin
			if (c < CH_ZERO || c > CH_NINE) begin
				ln_bad = 1'b1;
			end else begin
				case (ln_pos)
					8, 9:   slot = 0;
					11, 12: slot = 1;
					14, 15: slot = 2;
					17, 18: slot = 3;
					default: slot = -1;
				endcase
				if (slot >= 0)
					ln_val[slot] = (ln_val[slot] % 10) * 10 + (c - CH_ZERO);
			end
		end else if (c != sep) begin
			ln_bad = 1'b1;
		end
		ln_pos++;
		return st;
	endfunction

	// Updates the predicted state with one word and forms the result it should give.
	function automatic tod_pkg::result_t predict_tod(input tod_word_t w);
		tod_pkg::result_t r;
		int unsigned      sod;
		int unsigned      hr;
		r = '0;
		r.status = tod_pkg::ST_NONE;
		case (w.act)
			tod_pkg::ACT_TICK: tick_ms();
			tod_pkg::ACT_SEED: r.status = seed_time(w.hr, w.mn, w.sc, w.dy);
			tod_pkg::ACT_CHAR: r.status = take_line_char(w.ch);
			default: ;
		endcase
		if (tod_valid) begin
			sod = tod_sec % (tod_pkg::LAST_SEC_OF_DAY + 1);
			hr = sod / tod_pkg::SECS_PER_HOUR;
			r.valid = 1'b1;
			r.hour = 5'(hr);
			r.minute = 6'((sod % tod_pkg::SECS_PER_HOUR) / tod_pkg::SECS_PER_MIN);
			r.second = 6'(sod % tod_pkg::SECS_PER_MIN);
			r.sod = 17'(sod);
			r.day = 5'(tod_day);
			if (night_lo < night_hi)
				r.night = (hr >= night_lo && hr < night_hi);
			else if (night_lo > night_hi)
				r.night = (hr >= night_lo || hr < night_hi);
		end
		return r;
	endfunction

	// Sender: offers queued words, predicts each one as it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tod_result_q.push_back(predict_tod(word_cur));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (tod_word_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
					word_cur = tod_word_q.pop_front();
					in_valid <= 1'b1;
					action <= word_cur.act;
					hour_in <= word_cur.hr;
					minute_in <= word_cur.mn;
					second_in <= word_cur.sc;
					day_in <= word_cur.dy;
					char_in <= word_cur.ch;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (tod_result_q.size() == 0) begin
					report_mismatch($sformatf("result word %0d with nothing expected", n_results));
				end else begin
					want_res = tod_result_q.pop_front();
					check_field("seed_status", 32'(seed_status), 32'(want_res.status));
					check_field("time_valid", 32'(time_valid), 32'(want_res.valid));
					check_field("hour_out", 32'(hour_out), 32'(want_res.hour));
					check_field("minute_out", 32'(minute_out), 32'(want_res.minute));
					check_field("second_out", 32'(second_out), 32'(want_res.second));
					check_field("second_of_day_out", 32'(second_of_day_out),
						32'(want_res.sod));
					check_field("day_out", 32'(day_out), 32'(want_res.day));
					check_field("night_now", 32'(night_now), 32'(want_res.night));
				end
				n_results++;
			end
			out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// Long receiver hold-off so the block fills and stalls its input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("** time_of_day_keeper_with_iso_seed: FAILED **");
			$finish;
		end
	end

	// Write a night register, then read it back.
	task automatic write_night_hour(input logic sel, input logic [31:0] data);
		if (data[4:0] <= tod_pkg::MAX_HOUR) begin
			if (sel == tod_pkg::REG_NIGHT_START)
				night_lo = 32'(data[4:0]);
			else
				night_hi = 32'(data[4:0]);
		end
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== ((sel == tod_pkg::REG_NIGHT_START) ? night_lo : night_hi))
			report_mismatch($sformatf("night register %0d reads %0h", sel, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic tod_word_t rand_word(input logic [1:0] act);
		tod_word_t w;
		w.act = act;
		w.hr = 5'($urandom);
		w.mn = 6'($urandom);
		w.sc = 6'($urandom);
		w.dy = 6'($urandom);
		w.ch = 8'($urandom);
		return w;
	endfunction

	// Mostly in range, now and then anywhere the field allows.
	function automatic int unsigned biased(input int unsigned ok_max, input int unsigned all_max);
		return ($urandom_range(0, 6) == 0) ? $urandom_range(0, all_max) : $urandom_range(0, ok_max);
	endfunction

	task automatic queue_word(input tod_word_t w);
		tod_word_q.push_back(w);
		n_queued++;
	endtask

	task automatic queue_seed(input int unsigned hr, mn, sc, dy);
		tod_word_t w;
		w = rand_word(tod_pkg::ACT_SEED);
		w.hr = 5'(hr);
		w.mn = 6'(mn);
		w.sc = 6'(sc);
		w.dy = 6'(dy);
		queue_word(w);
	endtask

	task automatic queue_char(input logic [7:0] c);
		tod_word_t w;
		w = rand_word(tod_pkg::ACT_CHAR);
		w.ch = c;
		queue_word(w);
	endtask

	task automatic queue_ticks(input int unsigned n);
		repeat (n) queue_word(rand_word(tod_pkg::ACT_TICK));
	endtask

	// An ISO line with random digits, optionally broken, then its zero byte.
	task automatic queue_iso_line(input line_kind_t kind);
		logic [7:0]  ln[$];
		int unsigned dd, hh, mi, ss, d;
		dd = biased(31, 99);
		hh = biased(23, 99);
		mi = biased(59, 99);
		ss = biased(59, 99);
		for (int unsigned pos = 0; pos < tod_pkg::LINE_LEN; pos++) begin
			if (line_sep(pos) != NO_SEP) begin
				ln.push_back(line_sep(pos));
			end else begin
				case (pos)
					8:  d = dd / 10;
					9:  d = dd % 10;
					11: d = hh / 10;
					12: d = hh % 10;
					14: d = mi / 10;
					15: d = mi % 10;
					17: d = ss / 10;
					18: d = ss % 10;
					default: d = $urandom_range(0, 9);
				endcase
				ln.push_back(8'(CH_ZERO + d));
			end
		end
		case (kind)
			LINE_CORRUPT:
				ln[$urandom_range(0, tod_pkg::LINE_LEN - 1)] = 8'($urandom_range(1, 255));
			LINE_SHORT: begin
				d = $urandom_range(0, tod_pkg::LINE_LEN - 1);
				while (ln.size() > d) void'(ln.pop_back());
			end
			LINE_LONG: repeat ($urandom_range(1, 3)) ln.push_back(8'($urandom_range(1, 255)));
			default: ;
		endcase
		foreach (ln[i]) begin
			// Ticks may land in the middle of a line.
			if ($urandom_range(0, 19) == 0)
				queue_word(rand_word(tod_pkg::ACT_TICK));
			queue_char(ln[i]);
		end
		queue_char(CH_END);
	endtask

	task automatic queue_random_words(input int unsigned n);
		int unsigned first;
		int unsigned pick;
		tod_word_t   w;
		first = n_queued;
		while (n_queued - first < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				queue_iso_line(LINE_GOOD);
			end else if (pick < 42) begin
				queue_iso_line(line_kind_t'($urandom_range(LINE_CORRUPT, LINE_LONG)));
			end else if (pick < 65) begin
				queue_seed(biased(23, 31), biased(59, 63), biased(59, 63), biased(31, 63));
			end else if (pick < 88) begin
				queue_ticks($urandom_range(1, 30));
			end else if (pick < 94) begin
				queue_word(rand_word(ACT_UNUSED));
			end else begin
				w = rand_word(tod_pkg::ACT_CHAR);
				if ($urandom_range(0, 4) == 0)
					w.ch = CH_END;
				queue_word(w);
			end
		end
	endtask

	// Wait until every queued word is accepted and every result has come back.
	task automatic drain();
		while (n_accepted != n_queued || tod_result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] lo, hi, input int gap, stall);
		write_night_hour(tod_pkg::REG_NIGHT_START, lo);
		write_night_hour(tod_pkg::REG_NIGHT_END, hi);
		tx_gap_pct = gap;
		rx_stall_pct = stall;
		queue_random_words(PHASE_WORDS);
		drain();
	endtask

	// Main sequence.
	initial begin
		tod_valid = 1'b0;
		ms_cnt = 0;
		tod_sec = 0;
		tod_day = 1;
		ln_pos = 0;
		ln_bad = 1'b0;
		ln_val = '{default: 0};
		night_lo = 22;
		night_hi = 5;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ticks and unused action before any seed, empty line, range edges.
		queue_ticks(1);
		queue_word(rand_word(ACT_UNUSED));
		queue_char(CH_END);
		queue_seed(31, 0, 0, 1);
		queue_seed(0, 63, 0, 1);
		queue_seed(0, 0, 63, 1);
		queue_seed(0, 0, 0, 63);
		queue_seed(0, 0, 0, 32);
		queue_seed(0, 0, 0, 0);
		queue_ticks(1);
		queue_seed(23, 59, 59, 31);
		queue_seed(24, 59, 59, 1);
		queue_seed(23, 60, 0, 1);
		queue_seed(12, 0, 60, 1);
		queue_seed(23, 59, 59, 0);
		queue_word(rand_word(ACT_UNUSED));
		queue_char(8'hFF);
		queue_char(CH_END);
		queue_seed(0, 0, 0, 1);
		queue_ticks(1);
		drain();

		// Midnight and the day wrap, with a reseed that restarts the millisecond count.
		queue_seed(23, 59, 59, 31);
		queue_ticks(100);
		queue_seed(23, 59, 59, 31);
		queue_ticks(tod_pkg::TICKS_PER_SECOND + 1);
		queue_random_words(PHASE_WORDS);
		drain();

		run_phase(32'd0, 32'd23, 70, 0);
		write_night_hour(tod_pkg::REG_NIGHT_START, 32'd31);
		run_phase(32'd23, 32'd0, 0, 70);
		write_night_hour(tod_pkg::REG_NIGHT_END, 32'd24);
		run_phase(32'd7, 32'd7, 10, 10);

		// Back-pressure: the receiver holds off while the sender keeps offering.
		write_night_hour(tod_pkg::REG_NIGHT_START, {27'($urandom), 5'd3});
		write_night_hour(tod_pkg::REG_NIGHT_END, 32'd19);
		tx_gap_pct = 10;
		rx_stall_pct = 0;
		queue_random_words(PHASE_WORDS);
		hold_go = 1'b1;
		drain();

		if (mismatch_cnt == 0)
			$display("** time_of_day_keeper_with_iso_seed: PASSED **");
		else
			$display("** time_of_day_keeper_with_iso_seed: FAILED **");
		$finish;
	end

endmodule
